// ----- design/oll_pkg.sv -----
package oll_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int REQ_W = 3;
  localparam int ST_W  = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_VAL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INS_SORT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  at;
    logic [VAL_W-1:0]  item;
    logic              tok_start;
    logic              tok_step;
  } cell_cmd_t;

  // Compare flags reported by a cell that holds the scan token
  typedef struct packed {
    logic hit_eq;
    logic hit_ge;
  } cell_flag_t;

endpackage

// ----- design/oll_cell.sv -----
module oll_cell
  import oll_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] cell_index,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  input  logic             left_tok,
  output logic [VAL_W-1:0] val,
  output logic             tok,
  output cell_flag_t       flag,
  output logic [VAL_W-1:0] pick
);

  // Shift toward the tail on insert, toward the head on delete
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INS: begin
        if (cell_index > cmd.at) begin
          val <= left_val;
        end else if (cell_index == cmd.at) begin
          val <= cmd.item;
        end
      end
      CELL_DEL: begin
        if (cell_index >= cmd.at) begin
          val <= right_val;
        end
      end
      default: begin
      end
    endcase
  end

  // Scan token: load at the head, advance one cell per step
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (cmd.tok_start) begin
      tok <= (cell_index == '0);
    end else if (cmd.tok_step) begin
      tok <= left_tok;
    end
  end

  assign flag.hit_eq = tok & (val == cmd.item);
  assign flag.hit_ge = tok & (val >= cmd.item);
  assign pick        = (cell_index == cmd.at) ? val : '0;

endmodule

// ----- design/ordered_list_engine.sv -----
// Channel   Direction  Handshake             Payload
// in        inbound    in_valid / in_stall   req_type, position, item_value
// out       outbound   out_valid / out_stall status, removed_value, entry_count, value_sum
//
// Fixed requests (insert or delete at position, append, spare codes, a full-store
// sorted insert) commit from S_LOOK; delete value and a sorted insert that fits go on
// to S_SCAN and walk a token one cell a cycle to stop position k (first equal entry,
// or first entry not below the item for a sorted insert, else the entry count). Input stalls until commit.
// Reset clears the count, the sum and the handshake state; entries stay unread until written.
// A stalled output holds its result; the next request transfers and then waits for it.
module ordered_list_engine
  import oll_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [REQ_W-1:0]                     req_type,
  input  logic [POS_W-1:0]                     position,
  input  logic [VAL_W-1:0]                     item_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ST_W-1:0]                      status,
  output logic [VAL_W-1:0]                     removed_value,
  output logic [$clog2(CAPACITY+1)-1:0]        entry_count,
  output logic [VAL_W-1:0]                     value_sum
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [REQ_W-1:0]  req;
  logic [POS_W-1:0]  pos;
  logic [VAL_W-1:0]  item;
  logic [CNT_W-1:0]  count, count_next;
  logic [VAL_W-1:0]  sum, sum_next;
  logic [CNT_W-1:0]  k, k_next;

  cell_cmd_t         cmd;
  logic              commit;
  logic [ST_W-1:0]   st;
  logic [VAL_W-1:0]  rem;

  logic [VAL_W-1:0]  cell_val  [CAPACITY];
  logic              cell_tok  [CAPACITY];
  cell_flag_t        cell_flag [CAPACITY];
  logic [VAL_W-1:0]  cell_pick [CAPACITY];

  logic [VAL_W-1:0]  picked;
  logic              any_eq, any_ge;
  logic              full, out_free, scan_end, scan_hit;

  // ---------------------------------------------------------------------------
  // Cell chain: each cell sees its two neighbors' values and the left token
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] lv, rv;
    logic             lt;

    if (g == 0) begin : g_head
      assign lv = '0;
      assign lt = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[g-1];
      assign lt = cell_tok[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rv = '0;
    end else begin : g_body
      assign rv = cell_val[g+1];
    end

    oll_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (POS_W'(g)),
      .cmd        (cmd),
      .left_val   (lv),
      .right_val  (rv),
      .left_tok   (lt),
      .val        (cell_val[g]),
      .tok        (cell_tok[g]),
      .flag       (cell_flag[g]),
      .pick       (cell_pick[g])
    );
  end

  // Gather: only one cell matches the index, only one holds the token
  always_comb begin
    picked = '0;
    any_eq = 1'b0;
    any_ge = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      picked = picked | cell_pick[i];
      any_eq = any_eq | cell_flag[i].hit_eq;
      any_ge = any_ge | cell_flag[i].hit_ge;
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign full     = (count == CNT_W'(CAPACITY));
  // The cell at the count holds stale data, so the end test wins over a hit
  assign scan_end = (k == count);
  assign scan_hit = (req == REQ_DEL_VAL) ? any_eq : any_ge;

  always_comb begin
    state_next    = state;
    count_next    = count;
    sum_next      = sum;
    k_next        = k;
    commit        = 1'b0;
    st            = ST_DONE;
    rem           = '0;
    cmd.op        = CELL_HOLD;
    cmd.at        = pos;
    cmd.item      = item;
    cmd.tok_start = 1'b0;
    cmd.tok_step  = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        if (out_free) begin
          case (req)
            REQ_INS_POS: begin
              commit = 1'b1;
              if (pos > POS_W'(count)) begin
                st = ST_RANGE;
              end else if (full) begin
                st = ST_FULL;
              end else begin
                cmd.op     = CELL_INS;
                count_next = count + CNT_W'(1);
                sum_next   = sum + item;
              end
            end
            REQ_DEL_POS: begin
              commit = 1'b1;
              if (pos >= POS_W'(count)) begin
                st = ST_RANGE;
              end else begin
                cmd.op     = CELL_DEL;
                rem        = picked;
                count_next = count - CNT_W'(1);
                sum_next   = sum - picked;
              end
            end
            REQ_DEL_VAL: begin
              cmd.tok_start = 1'b1;
              k_next        = '0;
              state_next    = S_SCAN;
            end
            REQ_INS_SORT: begin
              if (full) begin
                commit = 1'b1;
                st     = ST_FULL;
              end else begin
                cmd.tok_start = 1'b1;
                k_next        = '0;
                state_next    = S_SCAN;
              end
            end
            REQ_APPEND: begin
              commit = 1'b1;
              if (full) begin
                st = ST_FULL;
              end else begin
                cmd.op     = CELL_INS;
                cmd.at     = POS_W'(count);
                count_next = count + CNT_W'(1);
                sum_next   = sum + item;
              end
            end
            default: begin
              commit = 1'b1;
            end
          endcase
          if (commit) begin
            state_next = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        cmd.at = POS_W'(k);
        if (scan_end || scan_hit) begin
          if (out_free) begin
            commit     = 1'b1;
            state_next = S_IDLE;
            if (req == REQ_DEL_VAL) begin
              if (scan_end) begin
                st = ST_NOTFOUND;
              end else begin
                cmd.op     = CELL_DEL;
                count_next = count - CNT_W'(1);
                sum_next   = sum - item;
              end
            end else begin
              cmd.op     = CELL_INS;
              count_next = count + CNT_W'(1);
              sum_next   = sum + item;
            end
          end
        end else begin
          // Advance the token to the next cell
          cmd.tok_step = 1'b1;
          k_next       = k + CNT_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      sum   <= sum_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the request and the result payloads
  always_ff @(posedge clk) begin
    k <= k_next;
    if (state == S_IDLE && in_valid) begin
      req  <= req_type;
      pos  <= position;
      item <= item_value;
    end
    if (commit) begin
      status        <= st;
      removed_value <= rem;
      entry_count   <= count_next;
      value_sum     <= sum_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_del_count: assert property (@(posedge clk) disable iff (rst)
    commit && cmd.op == CELL_DEL |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not drop the count by one");

  a_rose_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(commit))
    else $error("result shown without a commit");

  a_rem_zero: assert property (@(posedge clk) disable iff (rst)
    commit && cmd.op != CELL_DEL |-> rem == '0)
    else $error("removed value set outside a delete");

endmodule
